// ----- hdl/string_to_int64_parser_defines.svh -----
// Assertion macros for the string_to_int64_parser checker.
`ifndef STRING_TO_INT64_PARSER_DEFINES_SVH
`define STRING_TO_INT64_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define S2I_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define S2I_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/s2i_pkg.sv -----
// Shared types, character codes and digit decoders for the string parser.
package s2i_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned CHAR_W  = 8;

   // parse phases
   localparam logic [2:0] PH_SIGNS = 3'd0;
   localparam logic [2:0] PH_ZERO  = 3'd1;
   localparam logic [2:0] PH_DEC   = 3'd2;
   localparam logic [2:0] PH_HEX   = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;

   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } s2i_digit_type;

   // finished string: sign and magnitude before negation
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } s2i_raw_type;

   function automatic s2i_digit_type s2i_dec_digit(input logic [CHAR_W-1:0] c);
      s2i_digit_type d;
      logic [CHAR_W-1:0] diff;
      diff  = c - CH_0;
      d.ok  = (c >= CH_0) && (c <= CH_9);
      d.val = diff[3:0];
      return d;
   endfunction

   function automatic s2i_digit_type s2i_hex_digit(input logic [CHAR_W-1:0] c);
      s2i_digit_type d;
      logic [CHAR_W-1:0] diff;
      d = s2i_dec_digit(c);
      if (!d.ok) begin
         if (c >= CH_UP_A && c <= CH_UP_F) begin
            diff  = c - CH_UP_A + 8'd10;
            d.ok  = 1'b1;
            d.val = diff[3:0];
         end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            diff  = c - CH_LO_A + 8'd10;
            d.ok  = 1'b1;
            d.val = diff[3:0];
         end
      end
      return d;
   endfunction

endpackage

// ----- hdl/s2i_parse.sv -----
// Per-character parse state machine and 64-bit accumulator.
module s2i_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [s2i_pkg::CHAR_W-1:0]    in_char,
   input  logic                          in_last,
   output logic                          in_take,
   input  logic                          raw_ready,
   output logic                          raw_valid,
   output s2i_pkg::s2i_raw_type          raw
);
   import s2i_pkg::*;

   logic [2:0]         phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [2:0]         ph_step;
   logic               neg_step;
   logic [VALUE_W-1:0] acc_step;
   s2i_digit_type      dd, hd;
   logic [VALUE_W-1:0] acc_x10, acc_x16;

   assign dd = s2i_dec_digit(in_char);
   assign hd = s2i_hex_digit(in_char);

   // acc*10 = acc*8 + acc*2
   assign acc_x10 = {acc_ff[VALUE_W-4:0], 3'b000} + {acc_ff[VALUE_W-2:0], 1'b0}
                    + {{(VALUE_W-4){1'b0}}, dd.val};
   assign acc_x16 = {acc_ff[VALUE_W-5:0], hd.val};

   always_comb begin
      ph_step  = phase_ff;
      neg_step = neg_ff;
      acc_step = acc_ff;
      unique case (phase_ff)
         PH_SIGNS: begin
            if (in_char == CH_MINUS) begin
               neg_step = ~neg_ff;
            end else if (in_char == CH_PLUS) begin
               ph_step = PH_SIGNS;
            end else if (in_char == CH_0) begin
               acc_step = '0;
               ph_step  = PH_ZERO;
            end else if (dd.ok) begin
               acc_step = acc_x10;
               ph_step  = PH_DEC;
            end else begin
               ph_step = PH_DONE;
            end
         end
         PH_ZERO: begin
            if (in_char == CH_LO_X || in_char == CH_UP_X) begin
               ph_step = PH_HEX;
            end else if (dd.ok) begin
               acc_step = acc_x10;
               ph_step  = PH_DEC;
            end else begin
               ph_step = PH_DONE;
            end
         end
         PH_DEC: begin
            if (dd.ok) begin
               acc_step = acc_x10;
            end else begin
               ph_step = PH_DONE;
            end
         end
         PH_HEX: begin
            if (hd.ok) begin
               acc_step = acc_x16;
            end else begin
               ph_step = PH_DONE;
            end
         end
         default: ph_step = PH_DONE;
      endcase
   end

   // a last character waits here until the result stage has room
   assign in_take   = in_valid && (!in_last || raw_ready);
   assign raw_valid = in_valid && in_last;
   assign raw.neg   = neg_step;
   assign raw.mag   = acc_step;

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      if (in_take) begin
         if (in_last) begin
            phase_in = PH_SIGNS;
            neg_in   = 1'b0;
            acc_in   = '0;
         end else begin
            phase_in = ph_step;
            neg_in   = neg_step;
            acc_in   = acc_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIGNS;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

// ----- hdl/s2i_result.sv -----
// Result stages: holds the finished magnitude, then applies the sign into the output register.
module s2i_result (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          raw_valid,
   input  s2i_pkg::s2i_raw_type          raw,
   output logic                          raw_ready,
   output logic                          out_valid,
   output logic [s2i_pkg::VALUE_W-1:0]   out_value,
   input  logic                          out_ready
);
   import s2i_pkg::*;

   logic               hold_valid_ff, hold_valid_in;
   s2i_raw_type        hold_ff, hold_in;
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_ff, out_in;
   logic               out_free;

   assign out_free  = !out_valid_ff || out_ready;
   assign raw_ready = !hold_valid_ff || out_free;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (raw_ready) begin
         hold_valid_in = raw_valid;
         hold_in       = raw;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_free) begin
         out_valid_in = hold_valid_ff;
         out_in       = hold_ff.neg ? (VALUE_W'(0) - hold_ff.mag) : hold_ff.mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_ff;

endmodule

// ----- hdl/string_to_int64_parser.sv -----
// Top level: streaming decimal/hex string to 64-bit integer parser.
// Throughput: one character transaction per cycle, sustained, when rsp_tready stays high.
// The last character passes through the input, hold and output registers on its way to rsp_tvalid.
// Each character costs one shift-and-add on the accumulator; the sign is applied
//    in a stage of its own, off the accumulator path.
// Reset (synchronous, active high) empties all stages and returns the parser to sign phase.
module string_to_int64_parser (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // last_char
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [63:0] value
);
   import s2i_pkg::*;

   // input register stage
   logic              s0_valid_ff, s0_valid_in;
   logic [CHAR_W-1:0] s0_char_ff, s0_char_in;
   logic              s0_last_ff, s0_last_in;

   logic        s0_take;
   logic        raw_valid, raw_ready;
   s2i_raw_type raw;

   // input stage frees up whenever the parser consumes its character
   assign req_tready = !s0_valid_ff || s0_take;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_char_in  = s0_char_ff;
      s0_last_in  = s0_last_ff;
      if (req_tready) begin
         s0_valid_in = req_tvalid;
         s0_char_in  = req_tdata;
         s0_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_char_ff <= s0_char_in;
      s0_last_ff <= s0_last_in;
   end

   // sign run, "0x" prefix detection and digit accumulation
   s2i_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_char   (s0_char_ff),
      .in_last   (s0_last_ff),
      .in_take   (s0_take),
      .raw_ready (raw_ready),
      .raw_valid (raw_valid),
      .raw       (raw)
   );

   // hold register plus two's-complement output register; acts as the skid buffer
   s2i_result u_result (
      .clock     (clock),
      .reset     (reset),
      .raw_valid (raw_valid),
      .raw       (raw),
      .raw_ready (raw_ready),
      .out_valid (rsp_tvalid),
      .out_value (rsp_tdata),
      .out_ready (rsp_tready)
   );

endmodule

// ----- hdl/s2i_checker.sv -----
// Port-level checker for string_to_int64_parser and its bind.
`include "string_to_int64_parser_defines.svh"

module s2i_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // stalled result transaction must hold
   `S2I_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp stalled transaction changed")

   // input side never blocks while the output side can move
   `S2I_ASSERT_NOW(a_req_ready, clock, reset, !rsp_tvalid || rsp_tready, req_tready, "req_tready low with output free")

   // nothing comes out right after reset
   `S2I_ASSERT_NOW(a_rsp_reset, clock, reset, $past(reset), !rsp_tvalid, "rsp_tvalid high after reset")

endmodule

bind string_to_int64_parser s2i_checker u_s2i_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/string_to_int64_parser_test.sv -----
// Self-checking testbench for the streaming string to 64-bit integer parser.
module string_to_int64_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import s2i_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 29;
   localparam int HOLD_CYCLES = 400;

   // one character transaction as queued for the driver
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] character
   logic        req_tlast = 1'b0;   // last_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // [63:0] value

   char_item_type pending_chars[$]; // characters still to be offered
   logic [63:0] expected_values[$]; // parsed values still to come out
   logic [63:0] wanted_value;

   // predicted parser state
   logic [2:0]  parse_phase = PH_SIGNS;
   logic        parse_neg   = 1'b0;
   logic [63:0] parse_acc   = 64'd0;

   int  error_count  = 0;
   int  cycle_count  = 0;
   int  items_queued = 0;
   bit  steady_mode  = 1'b0;   // no idling on either side
   logic hold_request = 1'b0;  // asks the receiver for one long hold-off
   bit  hold_taken   = 1'b0;
   int  hold_left    = 0;

   string_to_int64_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Parser prediction for one accepted character; a final character pushes the value.
   task automatic track_char(input logic [7:0] c, input logic last);
      logic       is_dec;
      logic       is_hex;
      logic       take_dec;
      logic [7:0] digit8;
      is_dec = (c >= CH_0) && (c <= CH_9);
      is_hex = is_dec || ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
               ((c >= CH_LO_A) && (c <= CH_LO_F));
      if (is_dec)
         digit8 = c - CH_0;
      else if (c >= CH_LO_A)
         digit8 = c - CH_LO_A + 8'd10;
      else
         digit8 = c - CH_UP_A + 8'd10;
      take_dec = 1'b0;
      case (parse_phase)
         PH_SIGNS: begin
            if (c == CH_MINUS) begin
               parse_neg = ~parse_neg;
            end else if (c == CH_PLUS) begin
               // sign unchanged
            end else if (c == CH_0) begin
               parse_acc   = 64'd0;
               parse_phase = PH_ZERO;
            end else begin
               take_dec = 1'b1;
            end
         end
         PH_ZERO: begin
            if (c == CH_LO_X || c == CH_UP_X)
               parse_phase = PH_HEX;
            else
               take_dec = 1'b1;
         end
         PH_DEC: take_dec = 1'b1;
         PH_HEX: begin
            if (is_hex)
               parse_acc = (parse_acc << 4) + {56'd0, digit8};
            else
               parse_phase = PH_DONE;
         end
         default: parse_phase = PH_DONE;
      endcase
      if (take_dec) begin
         if (is_dec) begin
            parse_acc   = parse_acc * 64'd10 + {56'd0, digit8};
            parse_phase = PH_DEC;
         end else begin
            parse_phase = PH_DONE;
         end
      end
      if (last) begin
         expected_values.push_back(parse_neg ? 64'd0 - parse_acc : parse_acc);
         parse_phase = PH_SIGNS;
         parse_neg   = 1'b0;
         parse_acc   = 64'd0;
      end
   endtask

   task automatic queue_char(input logic [7:0] c, input logic last);
      char_item_type it;
      it.ch   = c;
      it.last = last;
      pending_chars.push_back(it);
      items_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++)
         queue_char(s[i], i == s.len() - 1);
   endtask

   // One random string: mostly well-formed numbers, some raw byte noise.
   task automatic queue_random_string(input bit short_only);
      logic [7:0] body[$];
      int kind;
      int n;
      int r;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         n = $urandom_range(1, 5);
         repeat (n) body.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 3))
            body.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
         if (short_only)
            n = $urandom_range(0, 2);
         else if ($urandom_range(0, 12) == 0)
            n = $urandom_range(17, 24);   // long enough that the accumulator can wrap
         else
            n = $urandom_range(0, 6);
         if (kind < 7) begin
            repeat (n) body.push_back(CH_0 + 8'($urandom_range(0, 9)));
         end else begin
            body.push_back(CH_0);
            body.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            repeat (n) begin
               r = $urandom_range(0, 21);
               if (r < 10)
                  body.push_back(CH_0 + 8'(r));
               else if (r < 16)
                  body.push_back(CH_UP_A + 8'(r - 10));
               else
                  body.push_back(CH_LO_A + 8'(r - 16));
            end
         end
         // trailing stray byte, sometimes followed by digits that must be ignored
         if ($urandom_range(0, 4) == 0) begin
            body.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2)) body.push_back(CH_0 + 8'($urandom_range(0, 9)));
         end
      end
      if (body.size() == 0)
         body.push_back(CH_PLUS);
      foreach (body[i])
         queue_char(body[i], i == body.size() - 1);
   endtask

   // sender pause: returns once every queued character is sent and every expected value has come back
   task automatic wait_drained();
      while (pending_chars.size() != 0 || expected_values.size() != 0)
         @(posedge clock);
   endtask

   // Driver: offer the head of pending_chars, hold it until accepted, idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            // transaction accepted at this edge
            track_char(req_tdata, req_tlast);
            void'(pending_chars.pop_front());
         end
         if (pending_chars.size() != 0 &&
             (steady_mode || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_chars[0].ch;
            req_tlast  <= pending_chars[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Monitor: each result transaction against the oldest expected value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("unexpected value %h", rsp_tdata));
         end else begin
            wanted_value = expected_values.pop_front();
            if (rsp_tdata !== wanted_value)
               report_mismatch($sformatf("value %h, expected %h", rsp_tdata, wanted_value));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed strings
      queue_char(8'hFF, 1'b1);      // stray top byte alone: 0
      queue_text("+-");             // signs only: 0
      queue_text("-0x");            // prefix without digits, negative: 0
      queue_text("-0XfA9");         // hex, both cases, negated
      queue_char("1", 1'b0);        // NUL stops parsing, later digit ignored: 12
      queue_char("2", 1'b0);
      queue_char(8'h00, 1'b0);
      queue_char("7", 1'b1);
      queue_text("07");             // leading zero taken as decimal digit
      queue_text("+9");
      wait_drained();

      // random with idling on both sides
      while (items_queued < 220)
         queue_random_string(1'b0);
      wait_drained();

      // long receiver hold-off while short strings keep coming: input must stall
      @(posedge clock);
      hold_request <= 1'b1;
      while (items_queued < 370)
         queue_random_string(1'b1);
      wait_drained();

      // stretch without any idling
      steady_mode = 1'b1;
      while (items_queued < 520)
         queue_random_string(1'b0);
      wait_drained();
      steady_mode = 1'b0;

      // random again, mixed lengths
      while (items_queued < 670)
         queue_random_string($urandom_range(0, 1));
      wait_drained();

      // result path is three registers deep; let any stray result show up
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
